### src/cbm_pkg.sv
// Shared widths, register codes, blend mode codes and stage-enable type
// for the color blend block. No dependencies.
package cbm_pkg;

	localparam int FRACTION_BITS = 12;

	// Port field widths
	localparam int IN_W      = 13;
	localparam int FACTOR_W  = 16;
	localparam int OUT_W     = 14;
	localparam int ALPHA_W   = 13;
	localparam int MODE_W    = 3;
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;

	// Internal datapath widths
	localparam int Q_W = FRACTION_BITS + 1;   // 0..ONE
	localparam int V_W = Q_W + 1;             // 0..2*ONE
	localparam int D_W = V_W + 1;             // signed v - x
	localparam int P_W = 2 * Q_W;             // mode product
	localparam int M_W = D_W + Q_W + 1;       // signed (v - x) * t

	localparam logic [Q_W-1:0] ONE  = Q_W'(1) << FRACTION_BITS;
	localparam logic [Q_W-1:0] HALF = ONE >> 1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_AMOUNT = 1'd1;

	// Blend modes; the unused code falls back to mix
	localparam logic [MODE_W-1:0] MODE_MIX      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ADD      = 3'd1;
	localparam logic [MODE_W-1:0] MODE_MULTIPLY = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SCREEN   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_OVERLAY  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_DARKEN   = 3'd5;
	localparam logic [MODE_W-1:0] MODE_LIGHTEN  = 3'd6;

	// Load enables for the five pipeline stages
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
	} pipe_en_t;

	function automatic logic [Q_W-1:0] sat_chan(input logic [IN_W-1:0] v);
		logic [Q_W-1:0] r;
		if (v > IN_W'(ONE)) begin
			r = ONE;
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

### src/color_blend_modes.sv
// Top level of the RGBA color blend block: config registers, factor select,
// four channel lanes and the merged output register. Depends on cbm_pkg,
// cbm_ctrl and cbm_lane.
//
//   Channel  | Handshake               | Payload
//   ---------+-------------------------+--------------------------------------
//   input    | in_valid / in_stall     | a_*, b_*, factor, factor_present
//   output   | out_valid / out_stall   | out_red, out_green, out_blue, out_alpha
//   config   | cfg_we                  | cfg_index, cfg_wdata
//
// One beat per clock sustained while out_stall is low; five stages (saturate,
// mode multiply, mode value, lerp multiply, output) carry each beat from the
// accepting edge into the output register. Reset clears valids and loads the
// register defaults. Stall on the output fills bubbles first; input stall
// rises only when every stage holds a beat.
module color_blend_modes (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [cbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cbm_pkg::CFG_W-1:0]       cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [cbm_pkg::IN_W-1:0]        a_red,
	input  logic [cbm_pkg::IN_W-1:0]        a_green,
	input  logic [cbm_pkg::IN_W-1:0]        a_blue,
	input  logic [cbm_pkg::IN_W-1:0]        a_alpha,
	input  logic [cbm_pkg::IN_W-1:0]        b_red,
	input  logic [cbm_pkg::IN_W-1:0]        b_green,
	input  logic [cbm_pkg::IN_W-1:0]        b_blue,
	input  logic [cbm_pkg::IN_W-1:0]        b_alpha,
	input  logic signed [cbm_pkg::FACTOR_W-1:0] factor,
	input  logic                            factor_present,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [cbm_pkg::OUT_W-1:0]       out_red,
	output logic [cbm_pkg::OUT_W-1:0]       out_green,
	output logic [cbm_pkg::OUT_W-1:0]       out_blue,
	output logic [cbm_pkg::ALPHA_W-1:0]     out_alpha
);
	import cbm_pkg::*;

	logic [MODE_W-1:0] blend_mode_q;
	logic [CFG_W-1:0]  default_amount_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blend_mode_q     <= MODE_MIX;
			default_amount_q <= CFG_W'(HALF);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BLEND_MODE:     blend_mode_q     <= cfg_wdata[MODE_W-1:0];
				REG_DEFAULT_AMOUNT: default_amount_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	pipe_en_t en;

	cbm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.en        (en)
	);

	// Clamp the blend factor to 0..ONE
	logic [Q_W-1:0] amount;

	always_comb begin
		if (factor_present) begin
			if (factor[FACTOR_W-1]) begin
				amount = '0;
			end else if (factor[FACTOR_W-2:0] > (FACTOR_W-1)'(ONE)) begin
				amount = ONE;
			end else begin
				amount = factor[Q_W-1:0];
			end
		end else begin
			amount = sat_chan(default_amount_q);
		end
	end

	logic [Q_W-1:0] amount_s1, amount_s2, amount_s3;

	always_ff @(posedge clk) begin
		if (en.s1) amount_s1 <= amount;
		if (en.s2) amount_s2 <= amount_s1;
		if (en.s3) amount_s3 <= amount_s2;
	end

	logic [V_W-1:0] res_red, res_green, res_blue, res_alpha;

	cbm_lane u_lane_red (
		.clk (clk), .en (en), .a (a_red), .b (b_red), .mode (blend_mode_q),
		.amount_s3 (amount_s3), .result (res_red)
	);

	cbm_lane u_lane_green (
		.clk (clk), .en (en), .a (a_green), .b (b_green), .mode (blend_mode_q),
		.amount_s3 (amount_s3), .result (res_green)
	);

	cbm_lane u_lane_blue (
		.clk (clk), .en (en), .a (a_blue), .b (b_blue), .mode (blend_mode_q),
		.amount_s3 (amount_s3), .result (res_blue)
	);

	// Alpha is a plain lerp toward B
	cbm_lane u_lane_alpha (
		.clk (clk), .en (en), .a (a_alpha), .b (b_alpha), .mode (MODE_MIX),
		.amount_s3 (amount_s3), .result (res_alpha)
	);

	always_ff @(posedge clk) begin
		if (en.s5) begin
			out_red   <= res_red[OUT_W-1:0];
			out_green <= res_green[OUT_W-1:0];
			out_blue  <= res_blue[OUT_W-1:0];
			out_alpha <= res_alpha[ALPHA_W-1:0];
		end
	end

endmodule

### src/cbm_ctrl.sv
// Valid tracking and stall propagation for the five-stage blend pipeline.
// Depends on cbm_pkg for the stage-enable struct.
module cbm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output cbm_pkg::pipe_en_t en
);
	import cbm_pkg::*;

	localparam int NUM_STG = 5;

	logic [NUM_STG-1:0] vld_q;
	logic [NUM_STG-1:0] rdy;
	logic [NUM_STG-1:0] ld;
	logic [NUM_STG-1:0] upstream;

	// A stage takes a beat when it is empty or its own content moves on
	always_comb begin
		rdy[NUM_STG-1] = !vld_q[NUM_STG-1] || !out_stall;
		for (int k = NUM_STG - 2; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign upstream = {vld_q[NUM_STG-2:0], in_valid};
	assign ld       = rdy & upstream;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 0; k < NUM_STG; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= upstream[k];
				end
			end
		end
	end

	assign in_stall  = !rdy[0];
	assign out_valid = vld_q[NUM_STG-1];

	assign en.s1 = ld[0];
	assign en.s2 = ld[1];
	assign en.s3 = ld[2];
	assign en.s4 = ld[3];
	assign en.s5 = ld[4];

endmodule

### src/cbm_lane.sv
// One color channel lane: saturate, mode product, mode value, lerp from A toward the mode value.
// Depends on cbm_pkg for widths, mode codes and the stage-enable struct.
module cbm_lane (
	input  logic                     clk,
	input  cbm_pkg::pipe_en_t        en,
	input  logic [cbm_pkg::IN_W-1:0] a,
	input  logic [cbm_pkg::IN_W-1:0] b,
	input  logic [cbm_pkg::MODE_W-1:0] mode,
	input  logic [cbm_pkg::Q_W-1:0]  amount_s3,
	output logic [cbm_pkg::V_W-1:0]  result
);
	import cbm_pkg::*;

	// Stage 1: saturated inputs
	logic [Q_W-1:0]    x_s1, y_s1;
	logic [MODE_W-1:0] mode_s1;

	always_ff @(posedge clk) begin
		if (en.s1) begin
			x_s1    <= sat_chan(a);
			y_s1    <= sat_chan(b);
			mode_s1 <= mode;
		end
	end

	// Stage 2: pick multiplier operands, or a direct value for the simple modes
	logic [Q_W-1:0] p, q;
	logic [V_W-1:0] alt;
	logic           use_prod, dbl, inv;

	always_comb begin
		p        = x_s1;
		q        = y_s1;
		alt      = V_W'(y_s1);
		use_prod = 1'b0;
		dbl      = 1'b0;
		inv      = 1'b0;
		case (mode_s1)
			MODE_ADD: begin
				alt = V_W'(x_s1) + V_W'(y_s1);
			end
			MODE_MULTIPLY: begin
				use_prod = 1'b1;
			end
			MODE_SCREEN: begin
				p        = ONE - x_s1;
				q        = ONE - y_s1;
				use_prod = 1'b1;
				inv      = 1'b1;
			end
			MODE_OVERLAY: begin
				use_prod = 1'b1;
				dbl      = 1'b1;
				if (x_s1 >= HALF) begin
					p   = ONE - x_s1;
					q   = ONE - y_s1;
					inv = 1'b1;
				end
			end
			MODE_DARKEN: begin
				alt = (x_s1 < y_s1) ? V_W'(x_s1) : V_W'(y_s1);
			end
			MODE_LIGHTEN: begin
				alt = (x_s1 > y_s1) ? V_W'(x_s1) : V_W'(y_s1);
			end
			default: begin
				alt = V_W'(y_s1);
			end
		endcase
	end

	logic [P_W-1:0] prod_s2;
	logic [V_W-1:0] alt_s2;
	logic [Q_W-1:0] x_s2;
	logic           use_prod_s2, dbl_s2, inv_s2;

	always_ff @(posedge clk) begin
		if (en.s2) begin
			prod_s2     <= P_W'(p) * P_W'(q);
			alt_s2      <= alt;
			x_s2        <= x_s1;
			use_prod_s2 <= use_prod;
			dbl_s2      <= dbl;
			inv_s2      <= inv;
		end
	end

	// Stage 3: finish the mode value and form v - x
	logic [P_W-1:0] sh_full;
	logic [V_W-1:0] sh, v;
	logic signed [D_W-1:0] d;

	always_comb begin
		// doubling the product is one bit less of downshift
		sh_full = dbl_s2 ? (prod_s2 >> (FRACTION_BITS - 1)) : (prod_s2 >> FRACTION_BITS);
		sh      = sh_full[V_W-1:0];
		if (!use_prod_s2) begin
			v = alt_s2;
		end else if (inv_s2) begin
			v = V_W'(ONE) - sh;
		end else begin
			v = sh;
		end
		d = $signed({1'b0, v}) - $signed({2'b00, x_s2});
	end

	logic signed [D_W-1:0] d_s3;
	logic [Q_W-1:0]        x_s3;

	always_ff @(posedge clk) begin
		if (en.s3) begin
			d_s3 <= d;
			x_s3 <= x_s2;
		end
	end

	// Stage 4: (v - x) * t
	logic signed [M_W-1:0] m_s4;
	logic [Q_W-1:0]        x_s4;

	always_ff @(posedge clk) begin
		if (en.s4) begin
			m_s4 <= M_W'(d_s3) * M_W'($signed({1'b0, amount_s3}));
			x_s4 <= x_s3;
		end
	end

	// Final add feeds the output register; arithmetic shift floors
	logic signed [M_W-1:0] sum;

	always_comb begin
		sum = $signed(M_W'({1'b0, x_s4})) + (m_s4 >>> FRACTION_BITS);
		if (sum < 0) begin
			result = '0;
		end else begin
			result = sum[V_W-1:0];
		end
	end

endmodule

### src/cbm_checker.sv
// Port-level checks for color_blend_modes and the bind that attaches them.
// Depends on cbm_pkg for field widths and the unit value.
module cbm_port_checks (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [cbm_pkg::OUT_W-1:0]       out_red,
	input logic [cbm_pkg::OUT_W-1:0]       out_green,
	input logic [cbm_pkg::OUT_W-1:0]       out_blue,
	input logic [cbm_pkg::ALPHA_W-1:0]     out_alpha
);
	import cbm_pkg::*;

	// Held output beat keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(out_alpha))
		else $error("output beat changed while stalled");

	// An empty output register means the pipe can take a beat
	assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output");

	// Without output stall an accepted beat reaches the output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
			##1 !out_stall |=> out_valid)
		else $error("accepted beat did not reach the output");

	// Results stay in range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_alpha <= ALPHA_W'(ONE) && out_red <= OUT_W'(2 * ONE)
			&& out_green <= OUT_W'(2 * ONE) && out_blue <= OUT_W'(2 * ONE))
		else $error("result out of range");

endmodule

bind color_blend_modes cbm_port_checks u_cbm_checker (.*);
